// ===== rtl/mbet_pkg.sv =====
package mbet_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF  = 28;
   localparam int ITER_BITS_DEF  = 16;
   localparam int PIXEL_BITS     = 12;
   localparam int COUNT_BITS     = 16;
   localparam int COLOUR_BITS    = 16;
   localparam int SCALE_BITS     = 17;
   localparam int ORIGIN_BITS    = 32;
   localparam int STEP_BITS      = 31;
   localparam int LIMIT_BITS     = 16;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEFT_RE      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_IM       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REAL_STEP    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IM_STEP      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_ITER     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLOUR_SCALE = 3'd5;

   localparam logic [ORIGIN_BITS-1:0] LEFT_RE_RST      = 32'hE000_0000;
   localparam logic [ORIGIN_BITS-1:0] MAX_IM_RST       = 32'h2000_0000;
   localparam logic [STEP_BITS-1:0]   REAL_STEP_RST    = 31'd1049600;
   localparam logic [STEP_BITS-1:0]   IM_STEP_RST      = 31'd1049600;
   localparam logic [LIMIT_BITS-1:0]  MAX_ITER_RST     = 16'd256;
   localparam logic [SCALE_BITS-1:0]  COLOUR_SCALE_RST = 17'd256;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel_x;
      logic [PIXEL_BITS-1:0] pixel_y;
   } req_word_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]  escape_count;
      logic                   inside_res;
      logic [COLOUR_BITS-1:0] colour;
   } rsp_word_type;

endpackage

// ===== rtl/mbet_front.sv =====
module mbet_front import mbet_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  req_word_type                 req_data,
   input  logic [ORIGIN_BITS-1:0]       left_re,
   input  logic [ORIGIN_BITS-1:0]       max_im,
   input  logic [STEP_BITS-1:0]         real_step,
   input  logic [STEP_BITS-1:0]         im_step,
   output logic                         q_push,
   input  logic                         q_full,
   output logic [2*COORD_BITS-1:0]      q_data
);

   localparam int PROD_BITS = PIXEL_BITS + STEP_BITS;
   localparam int BASE_BITS = (PROD_BITS > ORIGIN_BITS) ? PROD_BITS : ORIGIN_BITS;
   localparam int SUM_BITS  = (BASE_BITS + 2 > COORD_BITS + 1) ? BASE_BITS + 2 : COORD_BITS + 1;

   typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} state_type;

   state_type             state_ff;
   req_word_type          pix_ff;
   logic [PROD_BITS-1:0]  prod_x_ff;
   logic [PROD_BITS-1:0]  prod_y_ff;

   logic signed [SUM_BITS-1:0]   sum_r;
   logic signed [SUM_BITS-1:0]   sum_i;
   logic signed [COORD_BITS-1:0] cr;
   logic signed [COORD_BITS-1:0] ci;

   function automatic logic signed [COORD_BITS-1:0] sat_f(input logic signed [SUM_BITS-1:0] v);
      logic signed [SUM_BITS-1:0] hi;
      logic signed [SUM_BITS-1:0] lo;
      hi = $signed({{(SUM_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
      lo = ~hi;
      if (v > hi) begin
         sat_f = hi[COORD_BITS-1:0];
      end else if (v < lo) begin
         sat_f = lo[COORD_BITS-1:0];
      end else begin
         sat_f = v[COORD_BITS-1:0];
      end
   endfunction

   always_comb begin
      sum_r = $signed({{(SUM_BITS-ORIGIN_BITS){left_re[ORIGIN_BITS-1]}}, left_re})
            + $signed({{(SUM_BITS-PROD_BITS){1'b0}}, prod_x_ff});
      sum_i = $signed({{(SUM_BITS-ORIGIN_BITS){max_im[ORIGIN_BITS-1]}}, max_im})
            - $signed({{(SUM_BITS-PROD_BITS){1'b0}}, prod_y_ff});
      cr = sat_f(sum_r);
      ci = sat_f(sum_i);
   end

   assign req_full = (state_ff != F_IDLE);
   assign q_push   = (state_ff == F_PUSH) && !q_full;
   assign q_data   = {cr, ci};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (req_push) begin
                  pix_ff   <= req_data;
                  state_ff <= F_MUL;
               end
            end
            F_MUL: begin
               prod_x_ff <= {{(PROD_BITS-PIXEL_BITS){1'b0}}, pix_ff.pixel_x}
                          * {{(PROD_BITS-STEP_BITS){1'b0}}, real_step};
               prod_y_ff <= {{(PROD_BITS-PIXEL_BITS){1'b0}}, pix_ff.pixel_y}
                          * {{(PROD_BITS-STEP_BITS){1'b0}}, im_step};
               state_ff  <= F_PUSH;
            end
            F_PUSH: begin
               // hold the point until the queue has room
               if (!q_full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/mbet_queue.sv =====
module mbet_queue import mbet_pkg::*; #(
   parameter int WIDTH = 2 * COORD_BITS_DEF,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic                do_push;
   logic                do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/mbet_back.sv =====
module mbet_back import mbet_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int ITER_BITS  = ITER_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   output logic                    q_pop,
   input  logic [2*COORD_BITS-1:0] q_data,
   input  logic [LIMIT_BITS-1:0]   max_iterations,
   input  logic [SCALE_BITS-1:0]   colour_scale,
   input  logic                    rsp_pop,
   output logic                    rsp_empty,
   output rsp_word_type            rsp_data
);

   localparam int W       = 2 * COORD_BITS;
   localparam int MI_BITS = (ITER_BITS < LIMIT_BITS) ? ITER_BITS : LIMIT_BITS;
   localparam int CP_BITS = ITER_BITS + SCALE_BITS;
   localparam logic [W:0] ESC_LIMIT = (W+1)'(1) << (2 * FRAC_BITS + 2);

   typedef enum logic [1:0] {B_IDLE, B_MULT, B_STEP, B_COLOUR} state_type;

   state_type                    state_ff;
   logic signed [COORD_BITS-1:0] cr_ff;
   logic signed [COORD_BITS-1:0] ci_ff;
   logic signed [COORD_BITS-1:0] zr_ff;
   logic signed [COORD_BITS-1:0] zi_ff;
   logic signed [W-1:0]          sq_r_ff;
   logic signed [W-1:0]          sq_i_ff;
   logic signed [W-1:0]          cross_ff;
   logic [ITER_BITS-1:0]         iter_ff;
   logic [ITER_BITS-1:0]         count_ff;
   logic                         inside_ff;
   logic                         rsp_valid_ff;
   rsp_word_type                 rsp_data_ff;

   logic [ITER_BITS-1:0]         iter_limit;
   logic [W:0]                   mag;
   logic signed [W:0]            re;
   logic signed [W:0]            re_sh;
   logic signed [W-1:0]          im_sh;
   logic signed [W+1:0]          sum_r;
   logic signed [W+1:0]          sum_i;
   logic signed [COORD_BITS-1:0] zr_next;
   logic signed [COORD_BITS-1:0] zi_next;
   logic [CP_BITS-1:0]           colour_prod;
   logic [COLOUR_BITS-1:0]       colour_sat;
   logic                         slot_free;

   function automatic logic signed [COORD_BITS-1:0] sat_f(input logic signed [W+1:0] v);
      logic signed [W+1:0] hi;
      logic signed [W+1:0] lo;
      hi = $signed({{(W-COORD_BITS+3){1'b0}}, {(COORD_BITS-1){1'b1}}});
      lo = ~hi;
      if (v > hi) begin
         sat_f = hi[COORD_BITS-1:0];
      end else if (v < lo) begin
         sat_f = lo[COORD_BITS-1:0];
      end else begin
         sat_f = v[COORD_BITS-1:0];
      end
   endfunction

   always_comb begin
      iter_limit  = ITER_BITS'(max_iterations[MI_BITS-1:0]);
      // squares are never negative, so the plain sum is exact
      mag         = {1'b0, sq_r_ff} + {1'b0, sq_i_ff};
      re          = $signed({sq_r_ff[W-1], sq_r_ff}) - $signed({sq_i_ff[W-1], sq_i_ff});
      re_sh       = re >>> FRAC_BITS;
      im_sh       = cross_ff >>> (FRAC_BITS - 1);
      sum_r       = $signed({re_sh[W], re_sh})
                  + $signed({{(W+2-COORD_BITS){cr_ff[COORD_BITS-1]}}, cr_ff});
      sum_i       = $signed({{2{im_sh[W-1]}}, im_sh})
                  + $signed({{(W+2-COORD_BITS){ci_ff[COORD_BITS-1]}}, ci_ff});
      zr_next     = sat_f(sum_r);
      zi_next     = sat_f(sum_i);
      colour_prod = {{(CP_BITS-ITER_BITS){1'b0}}, count_ff}
                  * {{(CP_BITS-SCALE_BITS){1'b0}}, colour_scale};
      colour_sat  = (colour_prod > CP_BITS'({COLOUR_BITS{1'b1}})) ? {COLOUR_BITS{1'b1}}
                                                                 : colour_prod[COLOUR_BITS-1:0];
      slot_free   = !rsp_valid_ff || rsp_pop;
   end

   assign q_pop     = (state_ff == B_IDLE) && !q_empty;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a word loaded in B_COLOUR takes the slot over from the popped one
         if (rsp_pop && rsp_valid_ff && state_ff != B_COLOUR) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  cr_ff    <= q_data[W-1:COORD_BITS];
                  ci_ff    <= q_data[COORD_BITS-1:0];
                  zr_ff    <= '0;
                  zi_ff    <= '0;
                  iter_ff  <= '0;
                  state_ff <= B_MULT;
               end
            end
            B_MULT: begin
               sq_r_ff  <= zr_ff * zr_ff;
               sq_i_ff  <= zi_ff * zi_ff;
               cross_ff <= zr_ff * zi_ff;
               state_ff <= B_STEP;
            end
            B_STEP: begin
               // the squares belong to the z left by the previous iteration
               priority if (iter_ff != '0 && mag > ESC_LIMIT) begin
                  count_ff  <= iter_ff - 1'b1;
                  inside_ff <= 1'b0;
                  state_ff  <= B_COLOUR;
               end else if (iter_ff == iter_limit) begin
                  count_ff  <= '0;
                  inside_ff <= 1'b1;
                  state_ff  <= B_COLOUR;
               end else begin
                  zr_ff    <= zr_next;
                  zi_ff    <= zi_next;
                  iter_ff  <= iter_ff + 1'b1;
                  state_ff <= B_MULT;
               end
            end
            B_COLOUR: begin
               // hold the word until the result slot drains
               if (slot_free) begin
                  rsp_data_ff.escape_count <= COUNT_BITS'(count_ff);
                  rsp_data_ff.inside_res   <= inside_ff;
                  rsp_data_ff.colour       <= colour_sat;
                  rsp_valid_ff             <= 1'b1;
                  state_ff                 <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/mandelbrot_escape_time_pixel_top.sv =====
// Escape-time engine for one pixel of a Mandelbrot image.
// Request side is a queue input: drive req_data and raise req_push; the word
// is taken on a clock edge with req_push high and req_full low. The pixel is
// mapped to c = left_re + x*real_step + i*(max_im - y*im_step), then
// z = z*z + c is iterated from zero until |z|^2 exceeds 4 or the iteration
// limit is reached. Response side is a queue output: while rsp_empty is low
// rsp_data holds the oldest result; raise rsp_pop to take it.
// Registers are written through csr_valid/csr_ready (always ready), index and
// data; write them only while the engine is idle. Unknown indexes are dropped.
// Flow: the front end registers the pixel, then the two step products, and
// pushes the point into the two-entry queue. The back end loads c from the
// queue, then each iteration of its multiply/update loop passes B_MULT and
// B_STEP, and B_COLOUR fills the output slot. Each side works on one pixel at
// a time and takes a new one only after it has passed the last one on.
// Synchronous reset restores the default view, limit and colour scale and
// empties the engine. A stalled receiver holds one result in the output
// slot while the loop finishes the next pixel; further pixels wait in the
// queue and then req_full rises.
module mandelbrot_escape_time_pixel_top import mbet_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int ITER_BITS  = ITER_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  req_word_type              req_data,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output rsp_word_type              rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic [ORIGIN_BITS-1:0] left_re_ff;
   logic [ORIGIN_BITS-1:0] max_im_ff;
   logic [STEP_BITS-1:0]   real_step_ff;
   logic [STEP_BITS-1:0]   im_step_ff;
   logic [LIMIT_BITS-1:0]  max_iter_ff;
   logic [SCALE_BITS-1:0]  colour_scale_ff;

   logic                    q_push;
   logic                    q_full;
   logic                    q_pop;
   logic                    q_empty;
   logic [2*COORD_BITS-1:0] q_wdata;
   logic [2*COORD_BITS-1:0] q_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_re_ff      <= LEFT_RE_RST;
         max_im_ff       <= MAX_IM_RST;
         real_step_ff    <= REAL_STEP_RST;
         im_step_ff      <= IM_STEP_RST;
         max_iter_ff     <= MAX_ITER_RST;
         colour_scale_ff <= COLOUR_SCALE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LEFT_RE:      left_re_ff      <= csr_data[ORIGIN_BITS-1:0];
            CSR_MAX_IM:       max_im_ff       <= csr_data[ORIGIN_BITS-1:0];
            CSR_REAL_STEP:    real_step_ff    <= csr_data[STEP_BITS-1:0];
            CSR_IM_STEP:      im_step_ff      <= csr_data[STEP_BITS-1:0];
            CSR_MAX_ITER:     max_iter_ff     <= csr_data[LIMIT_BITS-1:0];
            CSR_COLOUR_SCALE: colour_scale_ff <= csr_data[SCALE_BITS-1:0];
            default: ;
         endcase
      end
   end

   mbet_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .left_re   (left_re_ff),
      .max_im    (max_im_ff),
      .real_step (real_step_ff),
      .im_step   (im_step_ff),
      .q_push    (q_push),
      .q_full    (q_full),
      .q_data    (q_wdata)
   );

   mbet_queue #(
      .WIDTH (2 * COORD_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .full      (q_full),
      .push_data (q_wdata),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_rdata)
   );

   mbet_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .ITER_BITS  (ITER_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .q_data         (q_rdata),
      .max_iterations (max_iter_ff),
      .colour_scale   (colour_scale_ff),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_data       (rsp_data)
   );

endmodule
